// ===== rtl/voice_adsr_envelope_generator_assert.svh =====
// assertion macros for the adsr envelope generator
`ifndef VOICE_ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define VOICE_ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== rtl/vadsr_pkg.sv =====
package vadsr_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_LOAD,
        S_DIV,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_SPARE   = 2'd3
    } t_phase;

    localparam logic [31:0] LEVEL_FULL = 32'h7FFF_FFFF;
    localparam logic [31:0] EXP_KNEE   = 32'h6000_0000;
    localparam logic [29:0] RATE_CLIP  = 30'h2000_0000;
    localparam logic [31:0] MASK_DECAY = 32'h07FF_FFFF;
    localparam logic [31:0] MASK_FALL  = 32'h0FFF_FFFF;
    localparam logic [31:0] LEN_FLAT   = 32'h7FFF_FFFF;
    localparam logic [31:0] LEN_NOSTEP = 32'h7FFF_FFFE;

    // doubling rate table, four entries per octave
    function automatic logic [29:0] rate_rom(input logic [7:0] idx);
        logic [7:0] k;
        logic [29:0] v;
        begin
            k = idx - 8'd32;
            v = '0;
            if (idx < 8'd24 || idx > 8'd159) begin
                v = '0;
            end else if (idx < 8'd32) begin
                case (idx[2:0])
                    3'd0, 3'd1, 3'd2, 3'd3: v = 30'd1;
                    3'd4, 3'd5:             v = 30'd2;
                    default:                v = 30'd3;
                endcase
            end else if (k[6:2] >= 5'd27) begin
                v = RATE_CLIP;
            end else begin
                v = 30'({1'b1, k[1:0]}) << k[6:2];
            end
            return v;
        end
    endfunction

    // extra rate index by top level bits in exponential fall
    function automatic logic [7:0] exp_offset(input logic [2:0] sel);
        logic [7:0] o;
        begin
            case (sel)
                3'd0:    o = 8'd0;
                3'd1:    o = 8'd4;
                3'd2:    o = 8'd6;
                3'd3:    o = 8'd8;
                3'd4:    o = 8'd9;
                3'd5:    o = 8'd10;
                3'd6:    o = 8'd11;
                default: o = 8'd12;
            endcase
            return o;
        end
    endfunction

endpackage

// ===== rtl/voice_adsr_envelope_generator.sv =====
// o_valid rises in the cycle after the accepting edge for key-on, off voice or bad index;
// it follows S_LOAD and S_FIN for a tick inside a segment or a segment start with no division,
// and S_LOAD, S_DIV (the shared restoring divider) and S_FIN for a segment start that divides.
// busy stays high from acceptance through the o_valid cycle, so no new item is taken until then.
// reset: synchronous active low; clears all voices to off and the sequencer to idle.
`include "voice_adsr_envelope_generator_assert.svh"
module voice_adsr_envelope_generator #(
    parameter int VOICE_COUNT = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [4:0]  i_voice,
    input  logic        i_release_held,
    input  logic [15:0] i_adsr_low,
    input  logic [15:0] i_adsr_high,
    output logic        o_valid,
    output logic [14:0] o_level,
    output logic        o_voice_active,
    output logic [4:0]  o_voice_out
);

    localparam int AW = (VOICE_COUNT > 1) ?
        (($clog2(VOICE_COUNT) > 5) ? 5 : $clog2(VOICE_COUNT)) : 1;
    localparam int MW = 98;

    vadsr_pkg::t_state r_state, n_state;

    // per-voice memory: phase, level, step, ticks left
    logic [MW-1:0] r_mem [VOICE_COUNT];
    logic [MW-1:0] r_rd;
    logic          mem_we;
    logic [MW-1:0] mem_wdata;
    logic [VOICE_COUNT-1:0] r_on, n_on;

    // latched item
    logic [4:0]  r_voice;
    logic        r_type, r_rel, r_quick, r_vok;
    logic [15:0] r_lo, r_hi;

    // work registers
    logic [31:0] r_lvl, n_lvl, r_step, n_step, r_len, n_len;
    logic [1:0]  r_phase, n_phase;
    logic        r_off, n_off;
    logic [29:0] r_rom, n_rom, r_rem, n_rem;
    logic [30:0] r_dvd, n_dvd;
    logic [4:0]  r_cnt, n_cnt;

    logic accept, in_vok;
    assign accept = start && !busy;
    assign in_vok = ({2'b0, i_voice} < 7'(VOICE_COUNT));

    // decoded fields of the loaded entry
    logic [1:0]  ld_phase;
    logic [31:0] ld_lvl, ld_step, ld_left;
    assign ld_phase = r_rd[97:96];
    assign ld_lvl   = r_rd[95:64];
    assign ld_step  = r_rd[63:32];
    assign ld_left  = r_rd[31:0];

    // segment start decision
    logic [31:0] lvl_c;
    logic [1:0]  seg_phase;
    logic        seg_div, seg_neg, seg_off, seg_done, seg_keep;
    logic [7:0]  seg_idx;
    logic [30:0] seg_dvd;
    logic [31:0] seg_len, seg_step;
    logic [6:0]  sr;
    logic [4:0]  rr;
    logic [3:0]  dr;
    logic [7:0]  rbase;
    logic [29:0] seg_rom;

    always_comb begin
        sr = r_hi[12:6];
        rr = r_hi[4:0];
        dr = r_lo[7:4];
        case (ld_lvl[31:30])
            2'd2:    lvl_c = vadsr_pkg::LEVEL_FULL;
            2'd3:    lvl_c = '0;
            default: lvl_c = ld_lvl;
        endcase
        seg_phase = ld_phase;
        seg_div   = 1'b0;
        seg_neg   = 1'b0;
        seg_off   = 1'b0;
        seg_done  = 1'b0;
        seg_keep  = 1'b0;
        seg_idx   = '0;
        seg_dvd   = '0;
        seg_len   = 32'd1;
        seg_step  = '0;
        rbase     = '0;
        if (r_rel) begin
            seg_done = 1'b1;
            if (lvl_c == '0) begin
                seg_off = 1'b1;
            end else if (r_hi[5]) begin
                seg_div = 1'b1;
                seg_neg = 1'b1;
                seg_idx = 8'd8 + {1'b0, rr ^ 5'h1F, 2'b00} +
                          vadsr_pkg::exp_offset(lvl_c[30:28]);
                seg_dvd = lvl_c[30:0] & vadsr_pkg::MASK_FALL[30:0];
            end else begin
                seg_div = 1'b1;
                seg_neg = 1'b1;
                seg_idx = 8'd20 + {1'b0, rr ^ 5'h1F, 2'b00};
                seg_dvd = lvl_c[30:0];
            end
        end
        // attack
        if (!seg_done && seg_phase == vadsr_pkg::PH_ATTACK) begin
            if (lvl_c != vadsr_pkg::LEVEL_FULL) begin
                seg_done = 1'b1;
                seg_div  = 1'b1;
                rbase = 8'd32 + {1'b0, r_lo[14:8] ^ 7'h7F};
                if (r_lo[15] && lvl_c >= vadsr_pkg::EXP_KNEE) begin
                    seg_idx = rbase - 8'd24;
                    seg_dvd = vadsr_pkg::LEVEL_FULL[30:0] - lvl_c[30:0];
                end else if (r_lo[15]) begin
                    seg_idx = rbase - 8'd16;
                    seg_dvd = vadsr_pkg::EXP_KNEE[30:0] - lvl_c[30:0];
                end else begin
                    seg_idx = rbase - 8'd16;
                    seg_dvd = vadsr_pkg::LEVEL_FULL[30:0] - lvl_c[30:0];
                end
            end else begin
                seg_phase = vadsr_pkg::PH_DECAY;
            end
        end
        // decay
        if (!seg_done && seg_phase == vadsr_pkg::PH_DECAY) begin
            if (lvl_c[30:27] > r_lo[3:0]) begin
                seg_done = 1'b1;
                seg_div  = 1'b1;
                seg_neg  = 1'b1;
                seg_idx  = 8'd8 + {1'b0, 1'b1, ~dr, 2'b00} +
                           vadsr_pkg::exp_offset(lvl_c[30:28]);
                seg_dvd  = lvl_c[30:0] & vadsr_pkg::MASK_DECAY[30:0];
            end else begin
                seg_phase = vadsr_pkg::PH_SUSTAIN;
            end
        end
        // sustain
        if (!seg_done && seg_phase == vadsr_pkg::PH_SUSTAIN) begin
            seg_done = 1'b1;
            rbase = 8'd32 + {1'b0, sr ^ 7'h7F};
            if (!r_hi[14]) begin
                if (lvl_c == vadsr_pkg::LEVEL_FULL) begin
                    seg_len = vadsr_pkg::LEN_FLAT;
                end else begin
                    seg_div = 1'b1;
                    if (r_hi[15] && lvl_c >= vadsr_pkg::EXP_KNEE) begin
                        seg_idx = rbase - 8'd24;
                        seg_dvd = vadsr_pkg::LEVEL_FULL[30:0] - lvl_c[30:0];
                    end else if (r_hi[15]) begin
                        seg_idx = rbase - 8'd16;
                        seg_dvd = vadsr_pkg::EXP_KNEE[30:0] - lvl_c[30:0];
                    end else begin
                        seg_idx = rbase - 8'd16;
                        seg_dvd = vadsr_pkg::LEVEL_FULL[30:0] - lvl_c[30:0];
                    end
                end
            end else if (lvl_c == '0) begin
                seg_len = vadsr_pkg::LEN_FLAT;
            end else if (r_hi[15]) begin
                seg_div = 1'b1;
                seg_neg = 1'b1;
                seg_idx = rbase - 8'd27 + vadsr_pkg::exp_offset(lvl_c[30:28]);
                seg_dvd = lvl_c[30:0] & vadsr_pkg::MASK_FALL[30:0];
            end else begin
                seg_div = 1'b1;
                seg_neg = 1'b1;
                seg_idx = rbase - 8'd15;
                seg_dvd = lvl_c[30:0];
            end
        end
        // spare phase code keeps its step for one tick
        if (!seg_done) begin
            seg_keep = 1'b1;
        end
        seg_rom = vadsr_pkg::rate_rom(seg_idx);
    end

    // shared restoring divider step
    logic [30:0] div_sh, div_diff, div_q;
    logic        div_ge;
    assign div_sh   = {r_rem, r_dvd[30]};
    assign div_ge   = (div_sh >= {1'b0, r_rom});
    assign div_diff = div_sh - {1'b0, r_rom};
    assign div_q    = {r_dvd[29:0], div_ge};

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_lvl     = r_lvl;
        n_step    = r_step;
        n_len     = r_len;
        n_phase   = r_phase;
        n_off     = r_off;
        n_rom     = r_rom;
        n_rem     = r_rem;
        n_dvd     = r_dvd;
        n_cnt     = r_cnt;
        n_on      = r_on;
        mem_we    = 1'b0;
        mem_wdata = {r_phase, r_lvl + r_step, r_step, r_len - 32'd1};
        busy           = (r_state != vadsr_pkg::S_IDLE);
        o_valid        = 1'b0;
        o_level        = '0;
        o_voice_active = 1'b0;
        o_voice_out    = r_voice;
        unique case (r_state)
            vadsr_pkg::S_IDLE: begin
                if (accept) begin
                    if (!in_vok || i_req_type || !r_on[i_voice[AW-1:0]]) begin
                        n_state = vadsr_pkg::S_RESP;
                    end else begin
                        n_state = vadsr_pkg::S_LOAD;
                    end
                end
            end
            vadsr_pkg::S_RESP: begin
                o_valid = 1'b1;
                if (r_vok && r_type) begin
                    mem_we    = 1'b1;
                    mem_wdata = {vadsr_pkg::PH_ATTACK, 32'd0, 32'd1, 32'd0};
                    n_on[r_voice[AW-1:0]] = 1'b1;
                    o_level        = 15'd1;
                    o_voice_active = 1'b1;
                end
                n_state = vadsr_pkg::S_IDLE;
            end
            vadsr_pkg::S_LOAD: begin
                n_off = 1'b0;
                if (ld_left != '0) begin
                    n_lvl   = ld_lvl;
                    n_step  = ld_step;
                    n_len   = ld_left;
                    n_phase = ld_phase;
                    n_state = vadsr_pkg::S_FIN;
                end else begin
                    n_lvl   = lvl_c;
                    n_phase = seg_phase;
                    n_off   = seg_off;
                    n_len   = seg_len;
                    n_step  = seg_keep ? ld_step : '0;
                    n_rom   = seg_rom;
                    n_state = vadsr_pkg::S_FIN;
                    if (seg_div) begin
                        if (seg_rom == '0) begin
                            n_len = vadsr_pkg::LEN_NOSTEP;
                        end else begin
                            n_step  = seg_neg ? (32'd0 - {2'b0, seg_rom}) : {2'b0, seg_rom};
                            n_dvd   = seg_dvd;
                            n_rem   = '0;
                            n_cnt   = '0;
                            n_state = vadsr_pkg::S_DIV;
                        end
                    end
                end
            end
            vadsr_pkg::S_DIV: begin
                n_rem = div_ge ? div_diff[29:0] : div_sh[29:0];
                n_dvd = div_q;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    n_len   = (div_q <= 31'd2) ? 32'd1 : ({1'b0, div_q} - 32'd1);
                    n_state = vadsr_pkg::S_FIN;
                end
            end
            vadsr_pkg::S_FIN: begin
                mem_we         = 1'b1;
                o_valid        = 1'b1;
                o_level        = r_lvl[30:16];
                o_voice_active = !r_off;
                if (r_off) begin
                    n_on[r_voice[AW-1:0]] = 1'b0;
                end
                n_state = vadsr_pkg::S_IDLE;
            end
            default: begin
                n_state = vadsr_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vadsr_pkg::S_IDLE;
            r_on    <= '0;
        end else begin
            r_state <= n_state;
            r_on    <= n_on;
        end
    end

    // item latch and work registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_voice <= i_voice;
            r_type  <= i_req_type;
            r_rel   <= i_release_held;
            r_lo    <= i_adsr_low;
            r_hi    <= i_adsr_high;
            r_vok   <= in_vok;
            r_quick <= !in_vok || i_req_type;
        end
        r_lvl   <= n_lvl;
        r_step  <= n_step;
        r_len   <= n_len;
        r_phase <= n_phase;
        r_off   <= n_off;
        r_rom   <= n_rom;
        r_rem   <= n_rem;
        r_dvd   <= n_dvd;
        r_cnt   <= n_cnt;
    end

    // voice memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_voice[AW-1:0]] <= mem_wdata;
        end
        if (accept) begin
            r_rd <= r_mem[i_voice[AW-1:0]];
        end
    end

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `ASSERT_NEXT(a_result_idle, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_SAME(a_div_nonzero, i_clk, i_rst_n, r_state == vadsr_pkg::S_DIV, r_rom != '0)
    `ASSERT_SAME(a_div_rem, i_clk, i_rst_n, r_state == vadsr_pkg::S_DIV, r_rem < r_rom)
    `ASSERT_SAME(a_quick_resp, i_clk, i_rst_n, r_state == vadsr_pkg::S_LOAD, !r_quick)

endmodule
